// ===== hdl/wes2d_pkg.sv =====
`timescale 1ns / 1ps

package wes2d_pkg;

    localparam int GRID_MAX   = 1024;
    localparam int VALUE_BITS = 32;
    localparam int COL_BITS   = $clog2(GRID_MAX);
    localparam int SIZE_BITS  = $clog2(GRID_MAX) + 1;
    localparam int COEF_BITS  = 24;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = COEF_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_COEF       = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_STEP = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRID_SIZE  = 2'd2;

    localparam logic [COEF_BITS-1:0] COEF_RESET = 24'd41943;
    localparam logic [SIZE_BITS-1:0] GRID_RESET = SIZE_BITS'(100);
    localparam logic [SIZE_BITS-1:0] GRID_MIN   = SIZE_BITS'(3);
    localparam logic [SIZE_BITS-1:0] GRID_TOP   = SIZE_BITS'(GRID_MAX);

    localparam int SHIFT_NORMAL = COEF_BITS;
    localparam int SHIFT_FIRST  = COEF_BITS + 1;

    localparam int LAP_BITS  = VALUE_BITS + 3;
    localparam int LO_BITS   = (LAP_BITS + 1) / 2;
    localparam int HI_BITS   = LAP_BITS - LO_BITS;
    localparam int PLO_BITS  = LO_BITS + COEF_BITS;
    localparam int PHI_BITS  = HI_BITS + COEF_BITS + 1;
    localparam int PROD_BITS = LAP_BITS + COEF_BITS + 1;
    localparam int SUM_BITS  = LAP_BITS + 2;

endpackage

// ===== hdl/wes2d_in_if.sv =====
`timescale 1ns / 1ps

interface wes2d_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [wes2d_pkg::VALUE_BITS-1:0] cur_value;
    logic signed [wes2d_pkg::VALUE_BITS-1:0] prev_value;

    modport source (output valid, output cur_value, output prev_value, input ready);
    modport sink   (input valid, input cur_value, input prev_value, output ready);
endinterface

// ===== hdl/wes2d_out_if.sv =====
`timescale 1ns / 1ps

interface wes2d_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [wes2d_pkg::VALUE_BITS-1:0] new_value;
    logic                                   frame_last;

    modport source (output valid, output new_value, output frame_last, input ready);
    modport sink   (input valid, input new_value, input frame_last, output ready);
endinterface

// ===== hdl/wes2d_cfg_if.sv =====
`timescale 1ns / 1ps

interface wes2d_cfg_if;
    logic                                     valid;
    logic                                     ready;
    logic [wes2d_pkg::CFG_INDEX_BITS-1:0]     index;
    logic [wes2d_pkg::CFG_DATA_BITS-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/wave_equation_2d_stencil.sv =====
`timescale 1ns / 1ps
// Pipeline: a result is computed when the request of the cell below its center cell is
// accepted; five register stages (r1, r2, r3, r4, output) from row store read to saturation.
// Throughput: one cell per cycle while o_out.ready does not stall; the row stores are read and written per cell.
// Reset (synchronous, active low): counters and stage valid bits clear, configuration registers take
// their defaults; row stores are not cleared and need no clearing pass.

module wave_equation_2d_stencil (
    input  logic               i_clk,
    input  logic               i_rst_n,
    wes2d_in_if.sink           i_in,
    wes2d_out_if.source        o_out,
    wes2d_cfg_if.sink          i_cfg
);

    localparam int VW   = wes2d_pkg::VALUE_BITS;
    localparam int CW   = wes2d_pkg::COL_BITS;
    localparam int SW   = wes2d_pkg::SIZE_BITS;
    localparam int KW   = wes2d_pkg::COEF_BITS;
    localparam int LW   = wes2d_pkg::LAP_BITS;
    localparam int LO   = wes2d_pkg::LO_BITS;
    localparam int PLW  = wes2d_pkg::PLO_BITS;
    localparam int PHW  = wes2d_pkg::PHI_BITS;
    localparam int PW   = wes2d_pkg::PROD_BITS;
    localparam int SUMW = wes2d_pkg::SUM_BITS;

    localparam logic signed [SUMW-1:0] SAT_MAX = {{(SUMW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_MIN = {{(SUMW-VW+1){1'b1}}, {(VW-1){1'b0}}};

    // configuration
    logic [KW-1:0] r_coef;
    logic          r_first;
    logic [SW-1:0] r_grid;
    logic [SW-1:0] grid_wr;

    // row stores
    logic signed [VW-1:0] upper_mem  [wes2d_pkg::GRID_MAX];
    logic signed [VW-1:0] center_mem [wes2d_pkg::GRID_MAX];
    logic signed [VW-1:0] prev_mem   [wes2d_pkg::GRID_MAX];

    // position
    logic [CW-1:0] r_col, r_row;
    logic [CW-1:0] n_col, n_row;
    logic [SW-1:0] col_in, row_a, c0, r0, c_inc, r_inc;
    logic          wrap_a, emit0, last0;
    logic [CW-1:0] addr0, addr_east;

    // stage enables
    logic en1, en2, en3, en4, en_out, accept;

    // stage 1
    logic                 r1_valid, r1_emit, r1_last;
    logic [CW-1:0]        r1_col;
    logic signed [VW-1:0] r1_cur, r1_old, r1_east, r1_north, r1_pold;
    logic signed [VW-1:0] r_west;

    // stage 2
    logic                 r2_valid, r2_last;
    logic signed [LW-1:0] r2_lap, r2_base;
    logic signed [LW-1:0] n_lap, n_base;

    // stage 3
    logic                  r3_valid, r3_last;
    logic        [PLW-1:0] r3_plo;
    logic signed [PHW-1:0] r3_phi;
    logic signed [LW-1:0]  r3_base;

    // stage 4
    logic                 r4_valid, r4_last;
    logic signed [PW-1:0] r4_prod;
    logic signed [LW-1:0] r4_base;
    logic signed [PW-1:0] round_half;

    // output
    logic                   r_out_valid, r_out_last;
    logic signed [VW-1:0]   r_out_value;
    logic signed [PW-1:0]   shifted;
    logic signed [SUMW-1:0] sum;
    logic signed [VW-1:0]   n_value;

    assign en_out = !r_out_valid || o_out.ready;
    assign en4    = !r4_valid || en_out;
    assign en3    = !r3_valid || en4;
    assign en2    = !r2_valid || en3;
    assign en1    = !r1_valid || en2;
    assign accept = i_in.valid && en1;

    assign i_in.ready       = en1;
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_valid;
    assign o_out.new_value  = r_out_value;
    assign o_out.frame_last = r_out_last;

    always_comb begin
        grid_wr = i_cfg.data[SW-1:0];
        if (grid_wr < wes2d_pkg::GRID_MIN) begin
            grid_wr = wes2d_pkg::GRID_MIN;
        end else if (grid_wr > wes2d_pkg::GRID_TOP) begin
            grid_wr = wes2d_pkg::GRID_TOP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= wes2d_pkg::COEF_RESET;
            r_first <= 1'b0;
            r_grid  <= wes2d_pkg::GRID_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                wes2d_pkg::CFG_COEF:       r_coef  <= i_cfg.data[KW-1:0];
                wes2d_pkg::CFG_FIRST_STEP: r_first <= i_cfg.data[0];
                wes2d_pkg::CFG_GRID_SIZE:  r_grid  <= grid_wr;
                default: ;
            endcase
        end
    end

    // wrap a position left beyond a shrunken grid, then find the next one
    always_comb begin
        col_in = SW'(r_col);
        wrap_a = col_in >= r_grid;
        c0     = wrap_a ? '0 : col_in;
        row_a  = wrap_a ? SW'(r_row) + SW'(1) : SW'(r_row);
        r0     = (row_a >= r_grid) ? '0 : row_a;
        emit0  = (r0 >= SW'(2)) && (c0 >= SW'(1)) && (c0 <= r_grid - SW'(2));
        last0  = (r0 == r_grid - SW'(1)) && (c0 == r_grid - SW'(2));
        c_inc  = c0 + SW'(1);
        r_inc  = r0 + SW'(1);
        if (c_inc >= r_grid) begin
            n_col = '0;
            n_row = (r_inc >= r_grid) ? '0 : r_inc[CW-1:0];
        end else begin
            n_col = c_inc[CW-1:0];
            n_row = r0[CW-1:0];
        end
        addr0     = c0[CW-1:0];
        addr_east = addr0 + CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_old             <= center_mem[addr0];
            r1_east            <= center_mem[addr_east];
            center_mem[addr0]  <= i_in.cur_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_pold          <= prev_mem[addr0];
            prev_mem[addr0]  <= i_in.prev_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_north <= upper_mem[addr0];
        end
        if (r1_valid && en2) begin
            upper_mem[r1_col] <= r1_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_emit <= emit0;
            r1_last <= last0;
            r1_col  <= addr0;
            r1_cur  <= i_in.cur_value;
        end
    end

    always_comb begin
        n_lap = LW'(r1_north) + LW'(r1_cur) + LW'(r1_east) + LW'(r_west)
              - (LW'(r1_old) <<< 2);
        if (r_first) begin
            n_base = LW'(r1_old);
        end else begin
            n_base = (LW'(r1_old) <<< 1) - LW'(r1_pold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid && r1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid) begin
            r_west  <= r1_old;
            r2_lap  <= n_lap;
            r2_base <= n_base;
            r2_last <= r1_last;
        end
    end

    // split multiply: low unsigned half and high signed half of the laplacian
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_plo  <= PLW'(r2_lap[LO-1:0]) * PLW'(r_coef);
            r3_phi  <= PHW'($signed(r2_lap[LW-1:LO])) * PHW'($signed({1'b0, r_coef}));
            r3_base <= r2_base;
            r3_last <= r2_last;
        end
    end

    assign round_half = r_first ? (PW'(1) <<< (wes2d_pkg::SHIFT_FIRST - 1))
                                : (PW'(1) <<< (wes2d_pkg::SHIFT_NORMAL - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (en4) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_prod <= (PW'(r3_phi) <<< LO) + $signed(PW'(r3_plo)) + round_half;
            r4_base <= r3_base;
            r4_last <= r3_last;
        end
    end

    always_comb begin
        shifted = r_first ? (r4_prod >>> wes2d_pkg::SHIFT_FIRST)
                          : (r4_prod >>> wes2d_pkg::SHIFT_NORMAL);
        sum = SUMW'(shifted) + SUMW'(r4_base);
        if (sum > SAT_MAX) begin
            n_value = SAT_MAX[VW-1:0];
        end else if (sum < SAT_MIN) begin
            n_value = SAT_MIN[VW-1:0];
        end else begin
            n_value = sum[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_value <= n_value;
            r_out_last  <= r4_last;
        end
    end

endmodule
